// ===== hdl/lspq_pkg.sv =====
// shared constants, codes and types for the linear-scan priority queue
// no dependencies; imported by every module of the block
package lspq_pkg;

  // store geometry
  localparam int DEPTH      = 16;
  localparam int FIND_LIMIT = 8;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FND_W      = $clog2(FIND_LIMIT + 1);

  // field widths
  localparam int KEY_W  = 32;
  localparam int PRIO_W = 8;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              have;
    logic              stop;
    logic [PRIO_W-1:0] best_prio;
    logic [IDX_W-1:0]  best_idx;
  } probe_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic             advance;
    logic             flush;
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic             shift;
    logic [IDX_W-1:0] shift_from;
  } cell_cmd_t;

  // cell index to the fixed-width position field
  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [IDX_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, idx};
    return ext[POS_W-1:0];
  endfunction

  // entry count to the fixed-width occupancy field
  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCC_W-1:0] ext;
    ext = {{OCC_W{1'b0}}, cnt};
    return ext[OCC_W-1:0];
  endfunction

endpackage

// ===== hdl/lspq_cell.sv =====
// one storage cell of the queue: an entry, its key match and the scan token stage
// depends on lspq_pkg
module lspq_cell
  import lspq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [KEY_W-1:0]  wr_key,
  input  logic [PRIO_W-1:0] wr_prio,
  input  logic [KEY_W-1:0]  nb_key,
  input  logic [PRIO_W-1:0] nb_prio,
  input  logic [KEY_W-1:0]  search_key,
  input  logic [PRIO_W-1:0] max_prio,
  input  probe_t            probe_in,
  output probe_t            probe_out,
  output logic [KEY_W-1:0]  key,
  output logic [PRIO_W-1:0] prio,
  output logic              hit
);

  probe_t probe_next;

  // entry storage: append at the tail, or close the gap left by a pop
  always_ff @(posedge clk) begin
    if (cmd.load && (idx == cmd.load_idx)) begin
      key  <= wr_key;
      prio <= wr_prio;
    end else if (cmd.shift && (idx >= cmd.shift_from)) begin
      key  <= nb_key;
      prio <= nb_prio;
    end
  end

  // key compare against the broadcast search key
  assign hit = (key == search_key);

  // running best update as the token passes this cell
  always_comb begin
    probe_next = probe_in;
    if (probe_in.active) begin
      if (!probe_in.have || (!probe_in.stop && (prio > probe_in.best_prio))) begin
        probe_next.have      = 1'b1;
        probe_next.stop      = (prio == max_prio);
        probe_next.best_prio = prio;
        probe_next.best_idx  = idx;
      end
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else if (cmd.flush) begin
      probe_out <= '0;
    end else if (cmd.advance) begin
      probe_out <= probe_next;
    end
  end

endmodule

// ===== hdl/linear_scan_priority_queue.sv =====
// Linear-scan priority queue: a row of storage cells, a scan token and the controller.
// Usage:
//   in channel (in_valid/in_ready) carries one operation per beat: func, entry_key,
//   entry_priority. out channel (out_valid/out_ready) carries result beats with
//   last set on the final beat of an operation. cfg_wr_en writes the stop priority.
// Operation flow:
//   one operation in flight at a time; ready returns the cycle after its final
//   beat is registered. Push, clear, and pop or find on an empty queue register
//   their result straight from the start state, with no walk. Pop and find walk a
//   token through the cells, one cell per cycle, a find pausing at a match while
//   its beat cannot be registered. A pop registers its result, and closes the gap,
//   when the walk ends at position p (early stop, else the tail); a find beat for
//   position p comes once the token reaches p at the earliest, later if earlier
//   beats waited on the receiver.
// Reset:
//   rst (synchronous) empties the queue, sets the stop priority to 255 and drops
//   any pending result. Stored entries are not cleared; only the fill count matters.
// Stall:
//   a result waits in the output register while out_ready is low; the scan holds
//   its place and nothing is lost.
module linear_scan_priority_queue
  import lspq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [PRIO_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [PRIO_W-1:0] entry_priority,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [KEY_W-1:0]  out_key,
  output logic [PRIO_W-1:0] out_priority,
  output logic [POS_W-1:0]  match_position,
  output logic [OCC_W-1:0]  occupancy,
  output logic              last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  pos, pos_next;
  logic [FND_W-1:0]  nfound, nfound_next;
  logic [PRIO_W-1:0] stop_prio;
  logic [FUNC_W-1:0] op_func;
  logic [KEY_W-1:0]  op_key;
  logic [PRIO_W-1:0] op_prio;

  cell_cmd_t         cmd;
  probe_t            inject;
  probe_t            probes [DEPTH];
  logic [KEY_W-1:0]  cell_key [DEPTH];
  logic [PRIO_W-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]  cell_hit;
  logic [DEPTH-1:0]  above;

  probe_t            cur;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              out_free;
  logic              pop_done;
  logic              hit_here;
  logic              more_after;
  logic              find_last;

  logic              post;
  logic [STAT_W-1:0] res_status;
  logic [KEY_W-1:0]  res_key;
  logic [PRIO_W-1:0] res_prio;
  logic [POS_W-1:0]  res_pos;
  logic [OCC_W-1:0]  res_occ;
  logic              res_last;

  // row of cells, token and shifted data move between neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    probe_t            p_in;
    logic [KEY_W-1:0]  n_key;
    logic [PRIO_W-1:0] n_prio;
    if (i == 0) begin : g_head
      assign p_in = inject;
    end else begin : g_body
      assign p_in = probes[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign n_key  = cell_key[i];
      assign n_prio = cell_prio[i];
    end else begin : g_link
      assign n_key  = cell_key[i+1];
      assign n_prio = cell_prio[i+1];
    end
    lspq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .wr_key     (op_key),
      .wr_prio    (op_prio),
      .nb_key     (n_key),
      .nb_prio    (n_prio),
      .search_key (op_key),
      .max_prio   (stop_prio),
      .probe_in   (p_in),
      .probe_out  (probes[i]),
      .key        (cell_key[i]),
      .prio       (cell_prio[i]),
      .hit        (cell_hit[i])
    );
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_prio <= '1;
    end else if (cfg_wr_en) begin
      stop_prio <= cfg_wr_data;
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func <= func;
      op_key  <= entry_key;
      op_prio <= entry_priority;
    end
  end

  // scan status
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cur      = probes[pos];
  assign cnt_m1   = count - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign pop_done = cur.stop || (pos == last_idx);
  assign rd_idx   = (op_func == FUNC_POP) ? cur.best_idx : pos;
  assign hit_here = cell_hit[pos];

  // live matches beyond the token
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      above[i] = (IDX_W'(i) > pos) && (CNT_W'(i) < count);
    end
  end
  assign more_after = |(cell_hit & above);
  assign find_last  = (nfound == FND_W'(FIND_LIMIT - 1)) || !more_after;

  // controller
  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    nfound_next = nfound;
    cmd         = '0;
    inject      = '0;
    post        = 1'b0;
    res_status  = STAT_OK;
    res_key     = '0;
    res_prio    = '0;
    res_pos     = '0;
    res_occ     = to_occ(count);
    res_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        case (op_func)
          FUNC_PUSH: begin
            if (out_free) begin
              post       = 1'b1;
              state_next = S_IDLE;
              if (count == CNT_W'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                cmd.load     = 1'b1;
                cmd.load_idx = count[IDX_W-1:0];
                count_next   = count + CNT_W'(1);
                res_occ      = to_occ(count + CNT_W'(1));
              end
            end
          end
          FUNC_CLEAR: begin
            if (out_free) begin
              post       = 1'b1;
              res_status = (count == '0) ? STAT_EMPTY : STAT_OK;
              res_occ    = '0;
              count_next = '0;
              state_next = S_IDLE;
            end
          end
          FUNC_POP, FUNC_FIND: begin
            if (count == '0) begin
              if (out_free) begin
                post       = 1'b1;
                res_status = STAT_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              inject.active = 1'b1;
              cmd.advance   = 1'b1;
              pos_next      = '0;
              nfound_next   = '0;
              state_next    = S_WALK;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (op_func == FUNC_POP) begin
          // pop: stop at the tail or early, then remove the winner
          if (pop_done) begin
            if (out_free) begin
              post           = 1'b1;
              res_key        = cell_key[rd_idx];
              res_prio       = cell_prio[rd_idx];
              res_pos        = to_pos(cur.best_idx);
              res_occ        = to_occ(cnt_m1);
              cmd.shift      = 1'b1;
              cmd.shift_from = cur.best_idx;
              cmd.flush      = 1'b1;
              count_next     = cnt_m1;
              state_next     = S_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
            pos_next    = pos + IDX_W'(1);
          end
        end else begin
          // find: one beat per matching cell up to FIND_LIMIT, last beat marked
          if (hit_here) begin
            if (out_free) begin
              post        = 1'b1;
              res_key     = cell_key[rd_idx];
              res_prio    = cell_prio[rd_idx];
              res_pos     = to_pos(pos);
              res_last    = find_last;
              nfound_next = nfound + FND_W'(1);
              if (find_last) begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
              end else begin
                cmd.advance = 1'b1;
                pos_next    = pos + IDX_W'(1);
              end
            end
          end else if (pos == last_idx) begin
            if (out_free) begin
              post       = 1'b1;
              res_status = STAT_EMPTY;
              cmd.flush  = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
            pos_next    = pos + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pos    <= '0;
      nfound <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pos    <= pos_next;
      nfound <= nfound_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      status         <= res_status;
      out_key        <= res_key;
      out_priority   <= res_prio;
      match_position <= res_pos;
      occupancy      <= res_occ;
      last           <= res_last;
    end
  end

endmodule

// ===== hdl/lspq_checker.sv =====
// port-level checks for the linear-scan priority queue, bound to the top level
// depends on lspq_pkg and linear_scan_priority_queue
module lspq_port_checks
  import lspq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic [KEY_W-1:0]  out_key,
  input logic [OCC_W-1:0]  occupancy,
  input logic              last
);

  // occupancy never exceeds the store
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy above depth");

  // a full report only when the store is full
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_FULL)) |-> (occupancy == OCC_W'(DEPTH)))
    else $error("full status with free cells");

  // a full report is always the only beat of its push
  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_FULL)) |-> last)
    else $error("full status without last");

  // one operation at a time: an accepted beat drops ready
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second operation accepted while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_key) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind linear_scan_priority_queue lspq_port_checks u_lspq_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_key   (out_key),
  .occupancy (occupancy),
  .last      (last)
);

// ===== test/lspq_checker.sv =====
// result checker for the linear-scan priority queue testbench
// depends on lspq_pkg; watches the config port and both channels of the block
module lspq_checker
  import lspq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [PRIO_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [PRIO_W-1:0] entry_priority,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [STAT_W-1:0] status,
  input  logic [KEY_W-1:0]  out_key,
  input  logic [PRIO_W-1:0] out_priority,
  input  logic [POS_W-1:0]  match_position,
  input  logic [OCC_W-1:0]  occupancy,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [POS_W-1:0]  pos;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } result_beat_t;

  // shadow copy of the queue contents and the stop priority
  logic [KEY_W-1:0]  q_keys  [DEPTH];
  logic [PRIO_W-1:0] q_prios [DEPTH];
  int                q_count = 0;
  logic [PRIO_W-1:0] stop_prio = 8'hFF;

  result_beat_t expected_beats[$];
  int           errors = 0;
  int           beats_waiting = 0;

  assign fail_count = errors;
  assign pending    = beats_waiting;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_beat(input logic [STAT_W-1:0] st, input logic [KEY_W-1:0] k,
                            input logic [PRIO_W-1:0] p, input logic [POS_W-1:0] pos,
                            input logic lst);
    result_beat_t b;
    b.status = st;
    b.key    = k;
    b.prio   = p;
    b.pos    = pos;
    b.occ    = OCC_W'(q_count);
    b.last   = lst;
    expected_beats.push_back(b);
  endtask

  // update the shadow queue for one operation and queue its result beats
  task automatic apply_queue_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                input logic [PRIO_W-1:0] p);
    int                best;
    int                hits;
    int                n;
    logic              stopped;
    logic [KEY_W-1:0]  k_out;
    logic [PRIO_W-1:0] p_out;
    logic [STAT_W-1:0] st;
    case (f)
      FUNC_PUSH: begin
        if (q_count >= DEPTH) begin
          queue_beat(STAT_FULL, '0, '0, '0, 1'b1);
        end else begin
          q_keys[q_count]  = k;
          q_prios[q_count] = p;
          q_count++;
          queue_beat(STAT_OK, '0, '0, '0, 1'b1);
        end
      end
      FUNC_POP: begin
        if (q_count == 0) begin
          queue_beat(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          // oldest-first scan, stopping once the best reaches the stop priority
          best    = 0;
          stopped = 1'b0;
          for (int i = 1; i < q_count && !stopped; i++) begin
            if (q_prios[best] == stop_prio) stopped = 1'b1;
            else if (q_prios[i] > q_prios[best]) best = i;
          end
          k_out = q_keys[best];
          p_out = q_prios[best];
          // later entries close the gap
          for (int i = best; i + 1 < q_count; i++) begin
            q_keys[i]  = q_keys[i+1];
            q_prios[i] = q_prios[i+1];
          end
          q_count--;
          queue_beat(STAT_OK, k_out, p_out, POS_W'(best), 1'b1);
        end
      end
      FUNC_CLEAR: begin
        st      = (q_count == 0) ? STAT_EMPTY : STAT_OK;
        q_count = 0;
        queue_beat(st, '0, '0, '0, 1'b1);
      end
      default: begin
        // find: matches in arrival order, capped, last one marked
        hits = 0;
        for (int i = 0; i < q_count; i++) if (q_keys[i] == k) hits++;
        if (hits > FIND_LIMIT) hits = FIND_LIMIT;
        if (hits == 0) begin
          queue_beat(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          n = 0;
          for (int i = 0; i < q_count && n < hits; i++) begin
            if (q_keys[i] == k) begin
              queue_beat(STAT_OK, q_keys[i], q_prios[i], POS_W'(i), n == hits - 1);
              n++;
            end
          end
        end
      end
    endcase
  endtask

  // compare one accepted result beat with the oldest expectation
  task automatic check_beat;
    result_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = expected_beats.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", status, want.status));
      if (out_key !== want.key)
        report_mismatch($sformatf("out_key got %0h want %0h", out_key, want.key));
      if (out_priority !== want.prio)
        report_mismatch($sformatf("out_priority got %0d want %0d", out_priority, want.prio));
      if (match_position !== want.pos)
        report_mismatch($sformatf("match_position got %0d want %0d", match_position,
                                  want.pos));
      if (occupancy !== want.occ)
        report_mismatch($sformatf("occupancy got %0d want %0d", occupancy, want.occ));
      if (last !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", last, want.last));
    end
  endtask

  // output beats first: they always belong to an earlier operation
  always @(posedge clk) begin
    if (rst) begin
      q_count   = 0;
      stop_prio = 8'hFF;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) check_beat();
      if (cfg_wr_en) stop_prio = cfg_wr_data;
      if (in_valid && in_ready) apply_queue_op(func, entry_key, entry_priority);
    end
    beats_waiting = expected_beats.size();
  end

endmodule

// ===== test/linear_scan_priority_queue_tb.sv =====
// testbench top for the linear-scan priority queue: clock, reset, stimulus, verdict
// depends on lspq_pkg, linear_scan_priority_queue and lspq_checker
module linear_scan_priority_queue_tb;
  import lspq_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = DEPTH + 12;
  localparam int RX_HOLD_CYCLES   = 200;
  localparam int RANDOM_PER_PHASE = 18;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [PRIO_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func = FUNC_PUSH;
  logic [KEY_W-1:0]  entry_key = '0;
  logic [PRIO_W-1:0] entry_priority = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  out_key;
  logic [PRIO_W-1:0] out_priority;
  logic [POS_W-1:0]  match_position;
  logic [OCC_W-1:0]  occupancy;
  logic              last;

  int fail_count;
  int pending;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_reqs    = 0;
  int cycles       = 0;
  logic [PRIO_W-1:0] stop_prio_now = 8'hFF;

  linear_scan_priority_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .entry_key      (entry_key),
    .entry_priority (entry_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_key        (out_key),
    .out_priority   (out_priority),
    .match_position (match_position),
    .occupancy      (occupancy),
    .last           (last)
  );

  lspq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .entry_key      (entry_key),
    .entry_priority (entry_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_key        (out_key),
    .out_priority   (out_priority),
    .match_position (match_position),
    .occupancy      (occupancy),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one operation beat, with a random gap first; valid stays up afterwards
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic [PRIO_W-1:0] p);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    func           <= f;
    entry_key      <= k;
    entry_priority <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // random operation, keys mostly from a small set so that finds hit
  task automatic send_random_op;
    int                roll;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0]  k;
    logic [PRIO_W-1:0] p;
    roll = $urandom_range(99);
    if (roll < 50)      f = FUNC_PUSH;
    else if (roll < 75) f = FUNC_POP;
    else if (roll < 93) f = FUNC_FIND;
    else                f = FUNC_CLEAR;
    case ($urandom_range(4))
      0:       k = 32'h0000_0000;
      1:       k = 32'hFFFF_FFFF;
      2:       k = 32'h1234_5678;
      3:       k = 32'h8000_0001;
      default: k = $urandom;
    endcase
    case ($urandom_range(3))
      0:       p = stop_prio_now;
      1:       p = PRIO_W'($urandom_range(3));
      default: p = PRIO_W'($urandom);
    endcase
    send_op(f, k, p);
  endtask

  // drop valid, wait for every expected beat, then let the block go quiet
  task automatic settle;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stop_prio(input logic [PRIO_W-1:0] v);
    settle();
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= v;
    stop_prio_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, fill to full, capped find, early-stopping pops
    send_op(FUNC_POP, 32'h0, 8'h0);
    send_op(FUNC_CLEAR, 32'hFFFF_FFFF, 8'hFF);
    send_op(FUNC_FIND, 32'h0, 8'h0);
    for (int i = 0; i < DEPTH; i++)
      send_op(FUNC_PUSH, (i == 1) ? 32'hFFFF_FFFF : ((i < 12) ? 32'h0 : $urandom),
              (i == 0) ? 8'h00 : ((i == 1) ? 8'hFF : PRIO_W'($urandom)));
    send_op(FUNC_PUSH, 32'hA5A5_A5A5, 8'h5A);
    send_op(FUNC_FIND, 32'h0, 8'h0);
    send_op(FUNC_FIND, 32'hFFFF_FFFF, 8'h0);
    send_op(FUNC_FIND, 32'h0BAD_F00D, 8'h0);
    send_op(FUNC_POP, 32'h0, 8'h0);
    send_op(FUNC_POP, 32'h0, 8'h0);
    send_op(FUNC_CLEAR, 32'h0, 8'h0);

    // random phases, each with its own stop priority and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_stop_prio(8'd0);
        1:       write_stop_prio(8'd128);
        2:       write_stop_prio(PRIO_W'($urandom));
        default: write_stop_prio(8'd255);
      endcase
      case (ph)
        0: begin
          tx_idle_pct  <= 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct  <= 79;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  <= 0;
          rx_stall_pct <= 79;
        end
        default: begin
          tx_idle_pct  <= 13;
          rx_stall_pct <= 13;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_op();
    end

    // back-pressure: receiver holds off while pushes keep coming past full
    settle();
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    send_op(FUNC_CLEAR, 32'h0, 8'h0);
    hold_reqs <= hold_reqs + 1;
    repeat (DEPTH + 4) send_op(FUNC_PUSH, $urandom, PRIO_W'($urandom));

    // sender pauses until every result is back, then a short mixed tail
    settle();
    tx_idle_pct  <= 13;
    rx_stall_pct <= 13;
    repeat (12) send_random_op();

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
